// ===== hw/rtl/pgpu_pkg.sv =====
`timescale 1ns / 1ps

package pgpu_pkg;

  // Fixed widths of the stream and of the configuration registers.
  localparam int unsigned BYTE_BITS  = 8;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned FIELD_W    = 4;
  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned PADDR_W    = 4;
  localparam int unsigned PDATA_W    = 32;

  localparam logic [BYTE_BITS-1:0] FULL_SCALE = 8'hFF;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_IMAGE_COLS = 2'd0;
  localparam logic [1:0] REG_IMAGE_ROWS = 2'd1;
  localparam logic [1:0] REG_FIELD_BITS = 2'd2;
  localparam logic [1:0] REG_MAX_LEVEL  = 2'd3;

  // Effective configuration, with the out-of-range codes already folded.
  typedef struct packed {
    logic [COUNT_W-1:0] cols;
    logic [COUNT_W-1:0] rows;
    logic [FIELD_W-1:0] width;
    logic [LEVEL_W-1:0] level;
  } cfg_t;

  // Status of the shared rescale divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BIT,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

// ===== hw/rtl/pgpu_cfg_regs.sv =====
`timescale 1ns / 1ps

module pgpu_cfg_regs
  import pgpu_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [COUNT_W-1:0] cols_r, cols_nxt;
  logic [COUNT_W-1:0] rows_r, rows_nxt;
  logic [FIELD_W-1:0] width_r, width_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic               wr_en;
  logic [1:0]         reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cols_nxt  = cols_r;
    rows_nxt  = rows_r;
    width_nxt = width_r;
    level_nxt = level_r;
    if (wr_en) begin
      case (reg_idx)
        REG_IMAGE_COLS: cols_nxt  = pwdata[COUNT_W-1:0];
        REG_IMAGE_ROWS: rows_nxt  = pwdata[COUNT_W-1:0];
        REG_FIELD_BITS: width_nxt = pwdata[FIELD_W-1:0];
        REG_MAX_LEVEL:  level_nxt = pwdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r  <= COUNT_W'(1);
      rows_r  <= COUNT_W'(1);
      width_r <= FIELD_W'(8);
      level_r <= LEVEL_W'(255);
    end else begin
      cols_r  <= cols_nxt;
      rows_r  <= rows_nxt;
      width_r <= width_nxt;
      level_r <= level_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_IMAGE_COLS: prdata = {{(PDATA_W-COUNT_W){1'b0}}, cols_r};
      REG_IMAGE_ROWS: prdata = {{(PDATA_W-COUNT_W){1'b0}}, rows_r};
      REG_FIELD_BITS: prdata = {{(PDATA_W-FIELD_W){1'b0}}, width_r};
      REG_MAX_LEVEL:  prdata = {{(PDATA_W-LEVEL_W){1'b0}}, level_r};
      default:        prdata = '0;
    endcase
  end

  // A zero limit counts as one; a field width outside one to eight is clamped.
  always_comb begin
    cfg.cols  = (cols_r == '0) ? COUNT_W'(1) : cols_r;
    cfg.rows  = (rows_r == '0) ? COUNT_W'(1) : rows_r;
    if (width_r == '0) begin
      cfg.width = FIELD_W'(1);
    end else if (width_r > FIELD_W'(8)) begin
      cfg.width = FIELD_W'(8);
    end else begin
      cfg.width = width_r;
    end
    cfg.level = level_r;
  end

endmodule

// ===== hw/rtl/pgpu_rescale_div.sv =====
`timescale 1ns / 1ps

module pgpu_rescale_div
  import pgpu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [BYTE_BITS-1:0] value,
  input  logic [LEVEL_W-1:0]   level,
  output div_stat_t            stat,
  output logic [BYTE_BITS-1:0] quotient
);

  logic [2*BYTE_BITS-1:0] dividend;
  logic                   sat;
  logic [BYTE_BITS-1:0]   rem_r, rem_nxt;
  logic [BYTE_BITS-1:0]   sh_r, sh_nxt;
  logic [LEVEL_W-1:0]     div_r, div_nxt;
  logic [2:0]             step_r, step_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [BYTE_BITS:0]     trial;
  logic                   ge;

  // value*255 as a shift and a subtract; the quotient overflows eight bits
  // exactly when the upper byte of the dividend already reaches the divisor,
  // which also covers a zero level.
  assign dividend = {value, {BYTE_BITS{1'b0}}} - {{BYTE_BITS{1'b0}}, value};
  assign sat      = dividend[2*BYTE_BITS-1:BYTE_BITS] >= level;

  assign trial = {rem_r, sh_r[BYTE_BITS-1]};
  assign ge    = trial >= {1'b0, div_r};

  always_comb begin
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    div_nxt  = div_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      div_nxt  = level;
      step_nxt = '0;
      if (sat) begin
        sh_nxt   = FULL_SCALE;
        done_nxt = 1'b1;
      end else begin
        rem_nxt  = dividend[2*BYTE_BITS-1:BYTE_BITS];
        sh_nxt   = dividend[BYTE_BITS-1:0];
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      // One restoring step: the remainder stays below the divisor, so the
      // trial value is below twice it and the difference fits a byte.
      rem_nxt  = ge ? BYTE_BITS'(trial - {1'b0, div_r}) : trial[BYTE_BITS-1:0];
      sh_nxt   = {sh_r[BYTE_BITS-2:0], ge};
      step_nxt = step_r + 3'd1;
      if (step_r == 3'd7) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    div_r <= div_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = sh_r;

`ifndef SYNTH
  a_busy_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(busy_r && done_r))
    else $error("divider busy and done together");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_done_after_step: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && step_r == 3'd7 && !start) |=> (done_r && !busy_r))
    else $error("divider did not finish after its last step");
`endif

endmodule

// ===== hw/rtl/packed_gray_pixel_unpacker.sv =====
`timescale 1ns / 1ps
// A byte is accepted in ST_IDLE and its bits are then taken one per cycle in
// ST_BIT, which pauses while each pixel that it completes waits in ST_DIV for
// the rescale divider (saturated, or divided bit by bit) and then in ST_OUT in
// the output register. A new byte is taken only once the previous one is done.
// Reset (synchronous, rst_n low) restores the register defaults and clears the
// bit collector, the row and column counters and the end-of-image flag.

module packed_gray_pixel_unpacker
  import pgpu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // Packed byte stream.
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [BYTE_BITS-1:0] in_packed_byte,
  // Pixel stream.
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [BYTE_BITS-1:0] out_gray_pixel,
  output logic                 out_end_of_row,
  output logic                 out_end_of_image,
  output logic                 out_last_of_run,
  // Configuration port.
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  cfg_t      cfg;
  div_stat_t div_stat;

  state_t state_r, state_nxt;

  // Byte being unpacked and the number of its bits not yet consumed.
  logic [BYTE_BITS-1:0] byte_r, byte_nxt;
  logic [FIELD_W-1:0]   left_r, left_nxt;
  // Field collector, which carries bits across byte boundaries.
  logic [BYTE_BITS-1:0] pf_r, pf_nxt;
  logic [FIELD_W-1:0]   cnt_r, cnt_nxt;
  // Position in the image.
  logic [COUNT_W-1:0]   col_r, col_nxt;
  logic [COUNT_W-1:0]   row_r, row_nxt;
  logic                 img_done_r, img_done_nxt;
  // Output register.
  logic [BYTE_BITS-1:0] gray_r, gray_nxt;
  logic                 eor_r, eor_nxt;
  logic                 eoi_r, eoi_nxt;
  logic                 last_r, last_nxt;

  logic                 div_start;
  logic [BYTE_BITS-1:0] div_q;

  logic [BYTE_BITS-1:0] pf_shift;
  logic [FIELD_W-1:0]   cnt_inc;
  logic [FIELD_W-1:0]   left_dec;
  logic                 field_done;
  logic [COUNT_W:0]     col_inc;
  logic [COUNT_W:0]     row_inc;
  logic                 eor;
  logic                 eoi;

  pgpu_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The single rescale unit, shared by every pixel of every byte.
  pgpu_rescale_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .value    (pf_shift),
    .level    (cfg.level),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // The stream is read most significant bit first, one bit per cycle except
  // while a pixel waits for the divider or the output. A field is complete when
  // its bit count reaches the width; the counters then tell whether it closes its row and the image.
  assign pf_shift   = {pf_r[BYTE_BITS-2:0], byte_r[BYTE_BITS-1]};
  assign cnt_inc    = cnt_r + FIELD_W'(1);
  assign left_dec   = left_r - FIELD_W'(1);
  assign field_done = cnt_inc >= cfg.width;
  assign col_inc    = {1'b0, col_r} + (COUNT_W+1)'(1);
  assign row_inc    = {1'b0, row_r} + (COUNT_W+1)'(1);
  assign eor        = col_inc >= {1'b0, cfg.cols};
  assign eoi        = eor && (row_inc >= {1'b0, cfg.rows});

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        // Bytes after the end of the image are accepted and dropped.
        if (in_valid && !img_done_r) begin
          state_nxt = ST_BIT;
        end
      end
      ST_BIT: begin
        if (field_done) begin
          state_nxt = ST_DIV;
        end else if (left_dec == '0) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        // Bits left in the byte after its last pixel still go into the
        // collector, unless the image has just ended.
        if (out_ready) begin
          state_nxt = (left_r == '0 || img_done_r) ? ST_IDLE : ST_BIT;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake outputs and the divider start.
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    div_start = 1'b0;
    case (state_r)
      ST_IDLE: in_ready  = 1'b1;
      ST_BIT:  div_start = field_done;
      ST_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end

  // Datapath.
  always_comb begin
    byte_nxt     = byte_r;
    left_nxt     = left_r;
    pf_nxt       = pf_r;
    cnt_nxt      = cnt_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    img_done_nxt = img_done_r;
    gray_nxt     = gray_r;
    eor_nxt      = eor_r;
    eoi_nxt      = eoi_r;
    last_nxt     = last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          byte_nxt = in_packed_byte;
          left_nxt = FIELD_W'(BYTE_BITS);
        end
      end
      ST_BIT: begin
        byte_nxt = {byte_r[BYTE_BITS-2:0], 1'b0};
        left_nxt = left_dec;
        if (field_done) begin
          pf_nxt  = '0;
          cnt_nxt = '0;
          eor_nxt = eor;
          eoi_nxt = eoi;
          // With the collector empty, a further pixel comes from this byte
          // only if its remaining bits cover a whole field.
          last_nxt = eoi || (left_dec < cfg.width);
          if (eor) begin
            col_nxt = '0;
            row_nxt = row_inc[COUNT_W-1:0];
          end else begin
            col_nxt = col_inc[COUNT_W-1:0];
          end
          if (eoi) begin
            // Any partial bits left over are dropped with the image.
            row_nxt      = '0;
            img_done_nxt = 1'b1;
          end
        end else begin
          pf_nxt  = pf_shift;
          cnt_nxt = cnt_inc;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          gray_nxt = div_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      left_r     <= '0;
      pf_r       <= '0;
      cnt_r      <= '0;
      col_r      <= '0;
      row_r      <= '0;
      img_done_r <= 1'b0;
      last_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      left_r     <= left_nxt;
      pf_r       <= pf_nxt;
      cnt_r      <= cnt_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      img_done_r <= img_done_nxt;
      last_r     <= last_nxt;
    end
    byte_r <= byte_nxt;
    gray_r <= gray_nxt;
    eor_r  <= eor_nxt;
    eoi_r  <= eoi_nxt;
  end

  assign out_gray_pixel   = gray_r;
  assign out_end_of_row   = eor_r;
  assign out_end_of_image = eoi_r;
  assign out_last_of_run  = last_r;

`ifndef SYNTH
  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("input taken while a pixel item is pending");

  a_eoi_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_end_of_image) |-> out_last_of_run)
    else $error("end of image not marked as last of run");

  a_silent_after_image: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && img_done_r) |=> !out_valid)
    else $error("pixel item produced after the end of the image");

  a_bits_available: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BIT) |-> (left_r != '0))
    else $error("bit step with no bits left in the byte");
`endif

endmodule
